// ----- design/svm_pkg.sv -----
// Package: shared constants, opcodes, event codes and control structs for the stack VM unit.
`default_nettype none
package svm_pkg;
    localparam int STACK_LIMIT_DEF   = 15;
    localparam int DATA_WORDS_DEF    = 256;
    localparam int PROGRAM_WORDS_DEF = 256;
    localparam logic [31:0] SYSCALL_PRINT   = 32'd1;
    localparam logic [31:0] SYSCALL_NEWLINE = 32'd4;

    typedef enum logic [3:0] {
        OP_PUSH = 4'd0, OP_POPR = 4'd1, OP_PUSR = 4'd2, OP_SCAL = 4'd3,
        OP_ADD = 4'd4, OP_SUB = 4'd5, OP_MUL = 4'd6, OP_DIV = 4'd7,
        OP_JUMP = 4'd8, OP_IFEQ = 4'd9, OP_IFNE = 4'd10, OP_INC = 4'd11,
        OP_DEC = 4'd12, OP_HALT = 4'd13, OP_FORE = 4'd14, OP_NOP = 4'd15
    } op_t;

    typedef enum logic [2:0] {
        EV_NONE = 3'd0, EV_PRINT = 3'd1, EV_NEWLINE = 3'd2, EV_DUMP = 3'd3,
        EV_HALTED = 3'd4
    } ev_t;

    typedef enum logic [2:0] {
        DC_IDLE = 3'd0, DC_LOAD = 3'd1, DC_CLEAR = 3'd2, DC_EXEC = 3'd3,
        DC_DIV = 3'd4, DC_FINISH = 3'd5, DC_DUMP = 3'd6
    } dp_cmd_t;

    typedef struct packed {
        logic    busy;
        dp_cmd_t op;
    } dp_ctrl_t;

    typedef struct packed {
        logic clear_done;
        logic div_done;
        logic dump_done;
        logic halted;
    } dp_stat_t;
endpackage
`default_nettype wire

// ----- design/svm_ram.sv -----
// Generic single-port RAM with registered read.
`default_nettype none
module svm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ----- design/svm_datapath.sv -----
// Datapath: stack registers, data memory, divider, program counter and result register.
`default_nettype none
module svm_datapath #(
    parameter int STACK_LIMIT   = 15,
    parameter int DATA_WORDS    = 256,
    parameter int PROGRAM_WORDS = 256
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire svm_pkg::dp_cmd_t  cmd,
    input  wire logic [3:0]        in_kind,
    input  wire logic [31:0]       in_a1,
    input  wire logic [31:0]       in_a2,
    input  wire logic [31:0]       in_a3,
    output svm_pkg::dp_stat_t      stat,
    output logic [8:0]             o_addr,
    output logic [2:0]             o_ev,
    output logic [31:0]            o_val,
    output logic                   o_dz,
    output logic                   o_last
);
    import svm_pkg::*;
    localparam int SPW = $clog2(STACK_LIMIT + 1);
    localparam int DAW = $clog2(DATA_WORDS);
    localparam logic [8:0] PEND = 9'(PROGRAM_WORDS);

    logic [31:0] stk_reg [STACK_LIMIT + 1];
    logic [SPW-1:0] sp_reg;
    logic [8:0] pc_reg;
    logic halted_reg;
    logic [DAW-1:0] clr_reg;
    logic clr_done_reg;
    logic [SPW-1:0] dump_reg;
    logic [4:0] div_cnt_reg;
    logic [31:0] dq_reg, drem_reg, dnum_reg, dden_reg;
    logic dneg_reg;
    logic [2:0] ev_reg;
    logic [31:0] val_reg;
    logic dz_reg, last_reg;
    logic [8:0] oaddr_reg;

    logic ram_we;
    logic [DAW-1:0] ram_addr;
    logic [31:0] ram_wdata, ram_rdata;

    svm_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_mem (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    logic a1_in_data;
    logic [31:0] top, sec, sec2;
    logic [SPW-1:0] sp1, sp2;
    logic [32:0] rem_sh;
    always_comb begin
        a1_in_data = !in_a1[31] && (in_a1 < 32'(DATA_WORDS));
        top = stk_reg[sp_reg];
        sp1 = (sp_reg != '0) ? sp_reg - 1'b1 : sp_reg;
        sp2 = (sp1 != '0) ? sp1 - 1'b1 : sp1;
        sec = stk_reg[sp1];
        sec2 = stk_reg[sp2];
        ram_we = 1'b0;
        ram_addr = in_a1[DAW-1:0];
        ram_wdata = top;
        if (cmd == DC_CLEAR) begin
            ram_we = 1'b1;
            ram_addr = clr_reg;
            ram_wdata = '0;
        end else if (cmd == DC_EXEC && in_kind == OP_POPR && a1_in_data) begin
            ram_we = 1'b1;
        end
        rem_sh = {drem_reg, dnum_reg[31]};
    end

    function automatic logic tok(input logic [31:0] t);
        return !t[31] && (t < 32'(PROGRAM_WORDS));
    endfunction

    assign stat.clear_done = clr_done_reg;
    assign stat.div_done = (div_cnt_reg == 5'd31);
    assign stat.dump_done = (dump_reg == SPW'(STACK_LIMIT - 1));
    assign stat.halted = halted_reg;
    assign o_addr = oaddr_reg;
    assign o_ev = ev_reg;
    assign o_val = val_reg;
    assign o_dz = dz_reg;
    assign o_last = last_reg;

    always_ff @(posedge aclk) begin
        logic [8:0] nxt;
        logic [31:0] r, x, y;
        logic [SPW-1:0] spn;
        logic dopush;
        nxt = (pc_reg < PEND) ? pc_reg + 1'b1 : PEND;
        r = '0;
        x = top;
        y = sec;
        spn = sp_reg;
        dopush = 1'b0;
        if (!aresetn) begin
            for (int i = 0; i <= STACK_LIMIT; i++) stk_reg[i] <= '0;
            sp_reg <= '0;
            pc_reg <= '0;
            halted_reg <= 1'b0;
            clr_reg <= '0;
            clr_done_reg <= 1'b0;
            dump_reg <= '0;
            div_cnt_reg <= '0;
        end else begin
            unique case (cmd)
                DC_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == DAW'(DATA_WORDS - 1)) clr_done_reg <= 1'b1;
                end
                DC_EXEC: begin
                    ev_reg <= EV_NONE; val_reg <= '0; dz_reg <= 1'b0; last_reg <= 1'b1;
                    dump_reg <= '0;
                    div_cnt_reg <= '0;
                    if (halted_reg) begin
                        ev_reg <= EV_HALTED;
                        oaddr_reg <= pc_reg;
                    end else begin
                        unique case (in_kind)
                            OP_PUSH: begin r = in_a1; dopush = 1'b1; end
                            OP_POPR, OP_PUSR, OP_DIV, OP_HALT: ;
                            OP_SCAL: begin
                                if (in_a1 == SYSCALL_PRINT) begin
                                    ev_reg <= EV_PRINT; val_reg <= top;
                                    stk_reg[sp_reg] <= (sp_reg != '0) ? '0 : top;
                                    sp_reg <= sp1;
                                end else if (in_a1 == SYSCALL_NEWLINE) ev_reg <= EV_NEWLINE;
                            end
                            OP_ADD, OP_SUB, OP_MUL: begin
                                if (in_kind == OP_ADD) r = x + y;
                                else if (in_kind == OP_SUB) r = x - y;
                                else r = x * y;
                                if (sp_reg != '0) stk_reg[sp_reg] <= '0;
                                if (sp1 != '0) stk_reg[sp1] <= '0;
                                spn = sp2;
                                if (spn < SPW'(STACK_LIMIT)) stk_reg[spn + 1'b1] <= r;
                                sp_reg <= (spn < SPW'(STACK_LIMIT)) ? spn + 1'b1 : spn;
                            end
                            OP_JUMP: if (tok(in_a1)) nxt = in_a1[8:0];
                            OP_IFEQ, OP_IFNE: begin
                                if (sp_reg != '0) stk_reg[sp_reg] <= '0;
                                sp_reg <= sp1;
                                if ((in_kind == OP_IFEQ) == (top == sec)) begin
                                    if (tok(in_a1)) nxt = in_a1[8:0];
                                end else if (tok(in_a2)) nxt = in_a2[8:0];
                            end
                            OP_INC: stk_reg[sp_reg] <= top + 1'b1;
                            OP_DEC: stk_reg[sp_reg] <= top - 1'b1;
                            OP_FORE: begin
                                if ($signed(in_a1) > $signed(top)) begin
                                    if (tok(in_a2)) nxt = in_a2[8:0];
                                end else if (tok(in_a3)) nxt = in_a3[8:0];
                            end
                            default: ;
                        endcase
                        if (in_kind == OP_POPR) begin
                            if (sp_reg != '0) stk_reg[sp_reg] <= '0;
                            sp_reg <= sp1;
                        end
                        if (dopush && sp_reg < SPW'(STACK_LIMIT)) begin
                            stk_reg[sp_reg + 1'b1] <= r;
                            sp_reg <= sp_reg + 1'b1;
                        end
                        if (in_kind == OP_DIV) begin
                            dneg_reg <= top[31] ^ sec[31];
                            dnum_reg <= top[31] ? 32'(0 - top) : top;
                            dden_reg <= sec[31] ? 32'(0 - sec) : sec;
                            drem_reg <= '0;
                            dq_reg <= '0;
                            dz_reg <= (sec == '0);
                        end
                        if (in_kind == OP_HALT) begin
                            oaddr_reg <= pc_reg;
                        end else if (in_kind != OP_DIV && in_kind != OP_PUSR) begin
                            pc_reg <= nxt;
                            oaddr_reg <= nxt;
                        end
                    end
                end
                DC_LOAD: begin
                    // pusr load step: registered memory word now valid
                    if (a1_in_data && sp_reg < SPW'(STACK_LIMIT)) begin
                        stk_reg[sp_reg + 1'b1] <= ram_rdata;
                        sp_reg <= sp_reg + 1'b1;
                    end
                    pc_reg <= nxt;
                    oaddr_reg <= nxt;
                end
                DC_DIV: begin
                    if (rem_sh >= {1'b0, dden_reg}) begin
                        drem_reg <= 32'(rem_sh - {1'b0, dden_reg});
                        dq_reg <= {dq_reg[30:0], 1'b1};
                    end else begin
                        drem_reg <= rem_sh[31:0];
                        dq_reg <= {dq_reg[30:0], 1'b0};
                    end
                    dnum_reg <= {dnum_reg[30:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                end
                DC_FINISH: begin
                    r = dz_reg ? '0 : (dneg_reg ? 32'(0 - dq_reg) : dq_reg);
                    if (sp_reg != '0) stk_reg[sp_reg] <= '0;
                    if (sp1 != '0) stk_reg[sp1] <= '0;
                    spn = sp2;
                    if (spn < SPW'(STACK_LIMIT)) stk_reg[spn + 1'b1] <= r;
                    sp_reg <= (spn < SPW'(STACK_LIMIT)) ? spn + 1'b1 : spn;
                    pc_reg <= nxt;
                    oaddr_reg <= nxt;
                end
                DC_DUMP: begin
                    ev_reg <= EV_DUMP;
                    val_reg <= stk_reg[dump_reg];
                    dz_reg <= 1'b0;
                    last_reg <= (dump_reg == SPW'(STACK_LIMIT - 1));
                    oaddr_reg <= pc_reg;
                    dump_reg <= dump_reg + 1'b1;
                    if (dump_reg == SPW'(STACK_LIMIT - 1)) halted_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_sp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SPW'(STACK_LIMIT)) else $error("stack pointer out of range");
    a_halt_pc: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> $stable(pc_reg)) else $error("pc moved after halt");
    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg <= PEND) else $error("pc out of range");
`endif
endmodule
`default_nettype wire

// ----- design/svm_ctrl.sv -----
// Controller: sequences clearing, execute, load, divide, dump and result handshake.
`default_nettype none
module svm_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire logic [3:0]        kind,
    input  wire svm_pkg::dp_stat_t stat,
    output svm_pkg::dp_cmd_t       cmd,
    output logic                   capture
);
    import svm_pkg::*;
    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_EXEC, S_LOAD, S_DIV, S_FIN, S_DUMP, S_OUT
    } state_t;
    state_t state_reg;
    logic dumping_reg, mv_reg;

    assign s_tready = (state_reg == S_IDLE) && !mv_reg;
    assign m_tvalid = mv_reg;
    assign capture = s_tvalid && s_tready;

    always_comb begin
        unique case (state_reg)
            S_CLEAR: cmd = DC_CLEAR;
            S_EXEC:  cmd = DC_EXEC;
            S_LOAD:  cmd = DC_LOAD;
            S_DIV:   cmd = DC_DIV;
            S_FIN:   cmd = DC_FINISH;
            S_DUMP:  cmd = (!mv_reg) ? DC_DUMP : DC_IDLE;
            default: cmd = DC_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            mv_reg <= 1'b0;
            dumping_reg <= 1'b0;
        end else begin
            if (mv_reg && m_tready) mv_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR: if (stat.clear_done) state_reg <= S_IDLE;
                S_IDLE: if (capture) state_reg <= S_EXEC;
                S_EXEC: begin
                    if (stat.halted) begin
                        mv_reg <= 1'b1; state_reg <= S_IDLE;
                    end else if (kind == OP_PUSR) state_reg <= S_LOAD;
                    else if (kind == OP_DIV) state_reg <= S_DIV;
                    else if (kind == OP_HALT) state_reg <= S_DUMP;
                    else begin mv_reg <= 1'b1; state_reg <= S_IDLE; end
                end
                S_LOAD: begin mv_reg <= 1'b1; state_reg <= S_IDLE; end
                S_DIV: if (stat.div_done) state_reg <= S_FIN;
                S_FIN: begin mv_reg <= 1'b1; state_reg <= S_IDLE; end
                S_DUMP: if (!mv_reg || m_tready) begin
                    if (!mv_reg) begin
                        mv_reg <= 1'b1;
                        dumping_reg <= !stat.dump_done;
                        if (stat.dump_done) state_reg <= S_OUT;
                    end
                end
                S_OUT: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("accept while result pending");
    a_exec_after: assert property (@(posedge aclk) disable iff (!aresetn)
        capture |=> state_reg == S_EXEC) else $error("exec skipped");
    a_dump_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DUMP && dumping_reg) |-> !s_tready) else $error("ready in dump");
`endif
endmodule
`default_nettype wire

// ----- design/stack_vm_execute_unit.sv -----
// Top level of the stack VM execute unit.
//  channel | dir | tdata (low bit first)                        | tuser
//  s_      | in  | kind[3:0] arg_one[35:4] arg_two[67:36] arg_three[99:68] | -
//  m_      | out | next_address[8:0] event_res[11:9] value[43:12] div_by_zero[44] | - (last on tlast)
// Sequence: most instructions are accepted, executed, then sent back as one result beat;
// pusr adds a load step for the memory read; div adds the quotient-bit steps and a finish step;
// halt emits STACK_LIMIT beats, each one only after the sink has taken the one before.
// Reset: a clearing pass writes zero over the data memory, with s_tready low.
// Stalls: a held result blocks the next accept; dump beats wait on m_tready.
`default_nettype none
module stack_vm_execute_unit #(
    parameter int STACK_LIMIT   = svm_pkg::STACK_LIMIT_DEF,
    parameter int DATA_WORDS    = svm_pkg::DATA_WORDS_DEF,
    parameter int PROGRAM_WORDS = svm_pkg::PROGRAM_WORDS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [103:0] s_tdata,  // kind, arg_one, arg_two, arg_three, zero pad
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [47:0]       m_tdata,  // next_address, event_res, value, div_by_zero, zero pad
    output logic              m_tlast
);
    import svm_pkg::*;

    dp_cmd_t cmd;
    dp_stat_t stat;
    logic capture;
    logic [3:0] kind_reg;
    logic [31:0] a1_reg, a2_reg, a3_reg;
    logic [8:0] o_addr;
    logic [2:0] o_ev;
    logic [31:0] o_val;
    logic o_dz;

    always_ff @(posedge aclk) begin
        if (capture) begin
            kind_reg <= s_tdata[3:0];
            a1_reg <= s_tdata[35:4];
            a2_reg <= s_tdata[67:36];
            a3_reg <= s_tdata[99:68];
        end
    end

    svm_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .kind(kind_reg), .stat(stat),
        .cmd(cmd), .capture(capture)
    );

    svm_datapath #(
        .STACK_LIMIT(STACK_LIMIT), .DATA_WORDS(DATA_WORDS), .PROGRAM_WORDS(PROGRAM_WORDS)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .in_kind(kind_reg), .in_a1(a1_reg),
        .in_a2(a2_reg), .in_a3(a3_reg), .stat(stat), .o_addr(o_addr), .o_ev(o_ev),
        .o_val(o_val), .o_dz(o_dz), .o_last(m_tlast)
    );

    assign m_tdata = {3'b000, o_dz, o_val, o_ev, o_addr};
endmodule
`default_nettype wire
